[rtl/adf_pkg.sv]
// Package for the alignment dominance filter: sizes, slot and pair records and sequencer states.
// No dependencies; used by every module under rtl.
`default_nettype none
package adf_pkg;
    localparam int PAIR_ENTRIES   = 64;
    localparam int SLOTS_PER_PAIR = 16;
    localparam int PW = $clog2(PAIR_ENTRIES);
    localparam int SW = $clog2(SLOTS_PER_PAIR);
    localparam int FW = $clog2(SLOTS_PER_PAIR + 1);
    localparam int AW = PW + SW;
    localparam logic [10:0] TOTAL_MAX = 11'd2047;

    typedef struct packed {
        logic [23:0]        sbj_start;
        logic [23:0]        sbj_stop;
        logic [23:0]        qry_start;
        logic [23:0]        qry_stop;
        logic signed [15:0] score;
    } t_slot;

    typedef struct packed {
        logic [31:0]   qkey;
        logic [31:0]   skey;
        logic [FW-1:0] fill;
    } t_pair;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_NEW, S_RD, S_CMP, S_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/alignment_dominance_filter_core.sv]
// Top level of the alignment dominance filter: pair lookup, list scan and compaction.
// Depends on adf_pkg and adf_slot_ram; the pair table is a local synchronous memory.
// Steps: a lookup over all pair entries, then a read and a compare per stored slot; a dominating
// slot ends the scan early when nothing has been removed before it.
// Throughput: one request at a time; busy falls as the strobe rises and the receiver cannot
// stall. Reset empties all pair entries and zeroes the total; memory contents stay undefined.
`default_nettype none
module alignment_dominance_filter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_query_db,
    input  wire logic [23:0] i_query_index,
    input  wire logic [7:0]  i_subject_db,
    input  wire logic [23:0] i_subject_index,
    input  wire logic [23:0] i_sbj_start,
    input  wire logic [23:0] i_sbj_stop,
    input  wire logic [23:0] i_qry_start,
    input  wire logic [23:0] i_qry_stop,
    input  wire logic signed [15:0] i_raw_score,
    output logic             o_valid,
    output logic             o_dominated,
    output logic [4:0]       o_removed_count,
    output logic             o_stored,
    output logic             o_new_pair,
    output logic             o_table_full,
    output logic [10:0]      o_total_alignments
);
    import adf_pkg::*;

    t_state r_state, n_state;
    t_pair r_pmem [0:PAIR_ENTRIES-1];
    t_pair r_prd;
    logic [PAIR_ENTRIES-1:0] r_used;
    logic [31:0] r_iq, r_is;
    t_slot r_item;
    logic [PW:0] r_p;
    logic [PW:0] r_free;
    logic [PW-1:0] r_lp;
    logic r_lv;
    logic [PW-1:0] r_pair;
    logic r_found, r_np, r_dom, r_full;
    logic [FW-1:0] r_fill_c, r_i, r_wp;
    logic [4:0] r_rem;
    logic [10:0] r_total;
    t_slot rd;
    logic we;
    logic [AW-1:0] waddr, raddr;
    t_slot wdata;
    logic dom_hit, rm_hit;
    logic store_ok;
    logic pwe;
    t_pair pwdata;
    logic [FW-1:0] fill_done;
    logic [10:0] total_done;

    adf_slot_ram u_ram (.i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd));

    always_ff @(posedge i_clk) begin
        if (pwe) r_pmem[r_pair] <= pwdata;
        r_prd <= r_pmem[r_p[PW-1:0]];
    end

    assign dom_hit = rd.sbj_start <= r_item.sbj_start && r_item.sbj_stop <= rd.sbj_stop &&
                     rd.qry_start <= r_item.qry_start && r_item.qry_stop <= rd.qry_stop &&
                     rd.score >= r_item.score;
    assign rm_hit = r_item.sbj_start <= rd.sbj_start && rd.sbj_stop <= r_item.sbj_stop &&
                    r_item.qry_start <= rd.qry_start && rd.qry_stop <= r_item.qry_stop;

    assign store_ok = (r_np || r_found) && !r_dom && r_wp != FW'(SLOTS_PER_PAIR);

    always_comb begin
        if (r_dom) fill_done = r_fill_c - FW'(r_rem);
        else if (r_wp == FW'(SLOTS_PER_PAIR)) fill_done = r_wp;
        else fill_done = r_wp + 1'b1;
        total_done = (store_ok && r_total != TOTAL_MAX) ? r_total + 1'b1 : r_total;
        pwe = r_state == S_DONE && (r_np || r_found);
        pwdata = {r_iq, r_is, fill_done};
    end

    // The read pointer r_i leads; kept slots, and every slot after a dominating one,
    // are written back at r_wp.
    always_comb begin
        raddr = {r_pair, r_i[SW-1:0]};
        we = 1'b0;
        waddr = {r_pair, r_wp[SW-1:0]};
        wdata = rd;
        if (r_state == S_CMP && (r_dom || dom_hit || !rm_hit) && r_wp != r_i) we = 1'b1;
        if (r_state == S_DONE && store_ok) begin
            we = 1'b1;
            wdata = r_item;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_LOOK;
            S_LOOK: if (r_p == (PW+1)'(PAIR_ENTRIES)) n_state = S_NEW;
            S_NEW:  n_state = S_RD;
            S_RD:   n_state = (r_full || r_i >= r_fill_c) ? S_DONE : S_CMP;
            S_CMP:  n_state = (dom_hit && !r_dom && r_wp == r_i) ? S_DONE : S_RD;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        o_valid <= i_rst_n && r_state == S_DONE;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (start) begin
                    r_iq <= {i_query_db, i_query_index};
                    r_is <= {i_subject_db, i_subject_index};
                    r_item <= '{i_sbj_start, i_sbj_stop, i_qry_start, i_qry_stop, i_raw_score};
                    r_p <= '0; r_free <= (PW+1)'(PAIR_ENTRIES); r_found <= 1'b0;
                    r_dom <= 1'b0; r_full <= 1'b0; r_np <= 1'b0; r_rem <= '0;
                    r_i <= '0; r_wp <= '0; r_lv <= 1'b0;
                end
                S_LOOK: begin
                    r_lv <= r_p < (PW+1)'(PAIR_ENTRIES);
                    if (r_p < (PW+1)'(PAIR_ENTRIES)) begin
                        r_p <= r_p + 1'b1;
                        r_lp <= r_p[PW-1:0];
                        if (!r_used[r_p[PW-1:0]] && r_free == (PW+1)'(PAIR_ENTRIES))
                            r_free <= r_p;
                    end
                    if (r_lv && r_used[r_lp] && !r_found && r_prd.qkey == r_iq &&
                        r_prd.skey == r_is) begin
                        r_found <= 1'b1; r_pair <= r_lp;
                        r_fill_c <= r_prd.fill;
                    end
                end
                S_NEW: if (!r_found) begin
                    if (r_free == (PW+1)'(PAIR_ENTRIES)) r_full <= 1'b1;
                    else begin
                        r_pair <= r_free[PW-1:0]; r_np <= 1'b1; r_fill_c <= '0;
                        r_used[r_free[PW-1:0]] <= 1'b1;
                    end
                end
                S_CMP: begin
                    r_i <= r_i + 1'b1;
                    if (r_dom || dom_hit) begin
                        r_dom <= 1'b1;
                        r_wp <= r_wp + 1'b1;
                    end else if (rm_hit) begin
                        r_rem <= r_rem + 1'b1;
                        if (r_total != '0) r_total <= r_total - 1'b1;
                    end else r_wp <= r_wp + 1'b1;
                end
                S_DONE: begin
                    o_dominated <= r_dom;
                    o_new_pair <= r_np;
                    o_removed_count <= r_rem;
                    o_stored <= store_ok;
                    o_table_full <= !r_dom && !store_ok;
                    o_total_alignments <= total_done;
                    r_total <= total_done;
                end
                default: ;
            endcase
        end
    end

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy);
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_stored && (o_table_full || o_dominated)));
    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_removed_count <= 5'(SLOTS_PER_PAIR));
endmodule
`default_nettype wire

[rtl/adf_slot_ram.sv]
// Slot memory for all pair lists, one synchronous port each for read and write.
// Depends on adf_pkg.
`default_nettype none
module adf_slot_ram (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [adf_pkg::AW-1:0] i_waddr,
    input  wire adf_pkg::t_slot i_wdata,
    input  wire logic [adf_pkg::AW-1:0] i_raddr,
    output adf_pkg::t_slot     o_rdata
);
    import adf_pkg::*;
    t_slot r_mem [0:PAIR_ENTRIES*SLOTS_PER_PAIR-1];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
